FILE: hdl/shp3_pkg.sv
// Shared types, constants and the per-channel sharpen function for the 3x3 sharpen filter.
`timescale 1ns / 1ps

package shp3_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CFGW_W     = 11;
  localparam int CFGH_W     = 12;
  localparam int STR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Line store depth default
  localparam int MAX_WIDTH_DEF = 1024;

  // Register reset values
  localparam logic [CFGW_W-1:0] WIDTH_RST    = 11'd640;
  localparam logic [CFGH_W-1:0] HEIGHT_RST   = 12'd480;
  localparam logic [STR_W-1:0]  STRENGTH_RST = 16'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_STRENGTH = 2'd2
  } cfg_idx_t;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // One line store word: row r-2 and row r-1 at the same column
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_word_t;

  // One result item
  typedef struct packed {
    logic   last;
    row_t   row;
    col_t   column;
    pixel_t pix;
  } res_t;

  // Results that one item hands to the output buffer
  typedef struct packed {
    logic has_int;
    logic has_brd;
    res_t int_res;
    res_t brd_res;
  } pair_t;

  // 5*center - north - south - west - east, gain in Q4.12, truncate, clamp 0..255
  function automatic logic [PIX_W-1:0] sharpen_chan(
    input logic [PIX_W-1:0] ctr,
    input logic [PIX_W-1:0] nn,
    input logic [PIX_W-1:0] ss,
    input logic [PIX_W-1:0] ww,
    input logic [PIX_W-1:0] ee,
    input logic [STR_W-1:0] gain
  );
    logic [10:0] pos;
    logic [9:0]  neg;
    logic [10:0] mag;
    logic [26:0] prod;
    logic [14:0] q;
    logic [PIX_W-1:0] res;
    pos  = {1'b0, ctr, 2'b00} + {3'b000, ctr};
    neg  = {2'b00, nn} + {2'b00, ss} + {2'b00, ww} + {2'b00, ee};
    mag  = pos - {1'b0, neg};
    prod = {16'd0, mag} * {11'd0, gain};
    q    = prod[26:12];
    if (pos <= {1'b0, neg}) begin
      res = '0;
    end else if (q > 15'd255) begin
      res = 8'hFF;
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/shp3_intf.sv
// Valid/ready stream interfaces for incoming pixels and result pixels.
`timescale 1ns / 1ps

interface shp3_in_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_start;
  logic [shp3_pkg::PIX_W-1:0]    blue;
  logic [shp3_pkg::PIX_W-1:0]    green;
  logic [shp3_pkg::PIX_W-1:0]    red;

  modport source (output valid, frame_start, blue, green, red, input ready);
  modport sink   (input valid, frame_start, blue, green, red, output ready);
endinterface

interface shp3_out_if;
  logic                          valid;
  logic                          ready;
  logic [shp3_pkg::PIX_W-1:0]    out_blue;
  logic [shp3_pkg::PIX_W-1:0]    out_green;
  logic [shp3_pkg::PIX_W-1:0]    out_red;
  logic [shp3_pkg::COL_W-1:0]    out_column;
  logic [shp3_pkg::ROW_W-1:0]    out_row;
  logic                          last_of_run;

  modport source (output valid, out_blue, out_green, out_red, out_column, out_row,
                  last_of_run, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_column, out_row,
                  last_of_run, output ready);
endinterface

FILE: hdl/shp3_line_store.sv
// Dual line store: one memory word per column holds rows r-2 and r-1, with write bypass.
`timescale 1ns / 1ps

module shp3_line_store #(
  parameter int DEPTH = shp3_pkg::MAX_WIDTH_DEF,
  parameter int DW    = $bits(shp3_pkg::line_word_t)
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  output logic [DW-1:0]            rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a same-column write in this cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: hdl/shp3_window.sv
// 3x3 pixel window (cross taps only) and the three channel sharpen kernels.
`timescale 1ns / 1ps

module shp3_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  shp3_pkg::pixel_t             col_up,
  input  shp3_pkg::pixel_t             col_mid,
  input  shp3_pkg::pixel_t             col_bot,
  input  logic [shp3_pkg::STR_W-1:0]   gain,
  output shp3_pkg::pixel_t             sharp
);

  // Taps: top and bottom rows need columns 1..2, middle row all three
  shp3_pkg::pixel_t top1_r, top2_r;
  shp3_pkg::pixel_t mid0_r, mid1_r, mid2_r;
  shp3_pkg::pixel_t bot1_r, bot2_r;

  // Shift one column left and load the new right column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top1_r <= '0;
      top2_r <= '0;
      mid0_r <= '0;
      mid1_r <= '0;
      mid2_r <= '0;
      bot1_r <= '0;
      bot2_r <= '0;
    end else if (shift_en) begin
      top1_r <= top2_r;
      top2_r <= col_up;
      mid0_r <= mid1_r;
      mid1_r <= mid2_r;
      mid2_r <= col_mid;
      bot1_r <= bot2_r;
      bot2_r <= col_bot;
    end
  end

  // Kernel per channel
  assign sharp.blue  = shp3_pkg::sharpen_chan(mid1_r.blue, top1_r.blue, bot1_r.blue,
                                              mid0_r.blue, mid2_r.blue, gain);
  assign sharp.green = shp3_pkg::sharpen_chan(mid1_r.green, top1_r.green, bot1_r.green,
                                              mid0_r.green, mid2_r.green, gain);
  assign sharp.red   = shp3_pkg::sharpen_chan(mid1_r.red, top1_r.red, bot1_r.red,
                                              mid0_r.red, mid2_r.red, gain);

endmodule

FILE: hdl/shp3_out_buf.sv
// Two-entry result buffer: splits an item's interior and border results into transfers.
`timescale 1ns / 1ps

module shp3_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_en,
  input  shp3_pkg::pair_t   pair,
  output logic              buf_ready,
  shp3_out_if.source        out_ch
);

  logic [1:0]     cnt_r, cnt_nxt;
  shp3_pkg::res_t slot0_r, slot0_nxt;
  shp3_pkg::res_t slot1_r, slot1_nxt;
  logic           pop;

  assign pop       = (cnt_r != 2'd0) && out_ch.ready;
  assign buf_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  // Pop the head, then load a new item into an emptied buffer
  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
    if (load_en) begin
      if (pair.has_int && pair.has_brd) begin
        slot0_nxt      = pair.int_res;
        slot0_nxt.last = 1'b0;
        slot1_nxt      = pair.brd_res;
        slot1_nxt.last = 1'b1;
        cnt_nxt        = 2'd2;
      end else if (pair.has_int) begin
        slot0_nxt      = pair.int_res;
        slot0_nxt.last = 1'b1;
        cnt_nxt        = 2'd1;
      end else if (pair.has_brd) begin
        slot0_nxt      = pair.brd_res;
        slot0_nxt.last = 1'b1;
        cnt_nxt        = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // Head of buffer drives the port
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.out_blue    = slot0_r.pix.blue;
  assign out_ch.out_green   = slot0_r.pix.green;
  assign out_ch.out_red     = slot0_r.pix.red;
  assign out_ch.out_column  = slot0_r.column;
  assign out_ch.out_row     = slot0_r.row;
  assign out_ch.last_of_run = slot0_r.last;

  // With two pending, the head is not last and the second is
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last))
    else $error("result pair has wrong last_of_run marks");

  // A load only lands in a buffer that is empty or drains its last entry this cycle
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |-> buf_ready)
    else $error("result buffer overrun");

  // A stalled pair never loses an entry
  a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_ch.ready) |=> (cnt_r == 2'd2))
    else $error("result lost while stalled");

endmodule

FILE: hdl/sharpen_3x3_filter_unit.sv
// Top level of the streaming 3x3 sharpen filter: counters, pipeline stages and config.
//
//  Channel  | Direction | Handshake    | Payload
//  ---------+-----------+--------------+--------------------------------------------------
//  in_ch    | sink      | valid/ready  | frame_start, blue, green, red
//  out_ch   | source    | valid/ready  | out_blue, out_green, out_red, out_column,
//           |           |              | out_row, last_of_run
//  cfg_*    | input     | cfg_we       | cfg_index (0 width, 1 height, 2 strength), cfg_data
//
//  One pixel is taken per cycle unless a stall holds in_ch.ready low; its results pass
//  through the stage 1, stage 2 and result buffer registers before they reach out_ch.
//  A pixel that yields both an interior and a border result holds the output for two
//  transfers, set by the single output port.
//  Reset is synchronous on rst_n; the line stores are not cleared and need no pass.
//  Stalls on out_ch back up through a two-entry result buffer and two stage registers.
`timescale 1ns / 1ps

module sharpen_3x3_filter_unit #(
  parameter int MAX_WIDTH = shp3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  shp3_in_if.sink                           in_ch,
  shp3_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [shp3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shp3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > shp3_pkg::CFGW_W) ? CW + 1 : shp3_pkg::CFGW_W;

  // Configuration registers
  logic [shp3_pkg::CFGW_W-1:0] width_r;
  logic [shp3_pkg::CFGH_W-1:0] height_r;
  logic [shp3_pkg::STR_W-1:0]  strength_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= shp3_pkg::WIDTH_RST;
      height_r   <= shp3_pkg::HEIGHT_RST;
      strength_r <= shp3_pkg::STRENGTH_RST;
    end else if (cfg_we) begin
      case (shp3_pkg::cfg_idx_t'(cfg_index))
        shp3_pkg::CFG_WIDTH:    width_r    <= cfg_data[shp3_pkg::CFGW_W-1:0];
        shp3_pkg::CFG_HEIGHT:   height_r   <= cfg_data[shp3_pkg::CFGH_W-1:0];
        shp3_pkg::CFG_STRENGTH: strength_r <= cfg_data[shp3_pkg::STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic acc0, go1, rdy1, rdy2, buf_ready, load_en;

  // Stage registers
  logic                    v1_r, int1_r, brd1_r;
  shp3_pkg::pixel_t        px1_r;
  logic [CW-1:0]           c1_r;
  shp3_pkg::row_t          r1_r;
  logic                    v2_r, int2_r, brd2_r;
  shp3_pkg::pixel_t        px2_r;
  logic [CW-1:0]           c2_r;
  shp3_pkg::row_t          r2_r;

  // Position counters
  logic [CW-1:0]           col_cnt_r, col_cnt_nxt;
  shp3_pkg::row_t          row_cnt_r, row_cnt_nxt;

  assign rdy2        = !v2_r || (!int2_r && !brd2_r) || buf_ready;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign acc0        = in_ch.valid && rdy1;
  assign go1         = v1_r && rdy2;
  assign load_en     = v2_r && (int2_r || brd2_r) && buf_ready;

  // Position of the incoming pixel and its border/interior class
  logic [CW-1:0]              c0;
  shp3_pkg::row_t             r0;
  logic [WW-1:0]              w_cfg, w_eff, c_plus;
  shp3_pkg::row_t             h_eff;
  logic [shp3_pkg::ROW_W:0]   r_plus;
  logic                       last_col, last_row, interior0, border0;
  shp3_pkg::pixel_t           px0;

  always_comb begin
    c0       = in_ch.frame_start ? '0 : col_cnt_r;
    r0       = in_ch.frame_start ? '0 : row_cnt_r;
    w_cfg    = WW'(width_r);
    if (w_cfg == '0) begin
      w_eff = WW'(1);
    end else if (w_cfg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    h_eff    = (height_r == '0) ? shp3_pkg::row_t'(1) : height_r;
    c_plus   = WW'(c0) + WW'(1);
    r_plus   = {1'b0, r0} + {{shp3_pkg::ROW_W{1'b0}}, 1'b1};
    last_col = (c_plus >= w_eff);
    last_row = (r_plus >= {1'b0, h_eff});
    interior0 = (r0 >= shp3_pkg::row_t'(2)) && (c0 >= CW'(2)) &&
                (r0 < h_eff) && (WW'(c0) < w_eff);
    border0  = (r0 == '0) || last_row || (c0 == '0) || last_col;
    px0.blue  = in_ch.blue;
    px0.green = in_ch.green;
    px0.red   = in_ch.red;
    // Counter advance
    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : r_plus[shp3_pkg::ROW_W-1:0];
    end else begin
      col_cnt_nxt = c_plus[CW-1:0];
      row_cnt_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc0) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (acc0) begin
      v1_r <= 1'b1;
    end else if (go1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc0) begin
      px1_r  <= px0;
      c1_r   <= c0;
      r1_r   <= r0;
      int1_r <= interior0;
      brd1_r <= border0;
    end
  end

  // Line stores: rows shift down by one at the pixel's column
  shp3_pkg::line_word_t rd_word, wr_word;

  assign wr_word.older = rd_word.newer;
  assign wr_word.newer = px1_r;

  shp3_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    ($bits(shp3_pkg::line_word_t))
  ) u_line_store (
    .clk       (clk),
    .rd_en     (acc0),
    .rd_addr   (c0),
    .wr_en     (go1),
    .wr_addr   (c1_r),
    .wr_data   (wr_word),
    .rd_data_r (rd_word)
  );

  // Stage 2: window holds the neighborhood one row and column back from this pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (go1) begin
      v2_r <= 1'b1;
    end else if (rdy2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      px2_r  <= px1_r;
      c2_r   <= c1_r;
      r2_r   <= r1_r;
      int2_r <= int1_r;
      brd2_r <= brd1_r;
    end
  end

  shp3_pkg::pixel_t sharp;

  shp3_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (go1),
    .col_up   (rd_word.older),
    .col_mid  (rd_word.newer),
    .col_bot  (px1_r),
    .gain     (strength_r),
    .sharp    (sharp)
  );

  // Results for the buffer: interior one row and column back, border in place
  shp3_pkg::pair_t pair;

  always_comb begin
    pair.has_int        = int2_r;
    pair.has_brd        = brd2_r;
    pair.int_res.pix    = sharp;
    pair.int_res.column = shp3_pkg::col_t'(c2_r - CW'(1));
    pair.int_res.row    = r2_r - shp3_pkg::row_t'(1);
    pair.int_res.last   = 1'b0;
    pair.brd_res.pix    = px2_r;
    pair.brd_res.column = shp3_pkg::col_t'(c2_r);
    pair.brd_res.row    = r2_r;
    pair.brd_res.last   = 1'b0;
  end

  shp3_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (load_en),
    .pair      (pair),
    .buf_ready (buf_ready),
    .out_ch    (out_ch)
  );

  // Frame start puts the pixel at the origin
  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (acc0 && in_ch.frame_start) |=> (v1_r && c1_r == '0 && r1_r == '0))
    else $error("frame start did not restart position");

  // Interior results only come from row and column two or beyond
  a_interior_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && int1_r) |-> (c1_r >= CW'(2) && r1_r >= shp3_pkg::row_t'(2)))
    else $error("interior flag on an edge position");

  // A stalled stage 2 keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy2) |=> (v2_r && $stable(c2_r) && $stable(r2_r)))
    else $error("stage 2 item dropped during stall");

endmodule
